/* sv/pns_pkg.sv */
// ----------------------------------------------------------------------------
// PLL nearest-setting search: shared package
// Types, constants, register map and word packing used by the search block.
// ----------------------------------------------------------------------------
`default_nettype none

package pns_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 128;
   localparam int REF_W               = 26;
   localparam int MUL_W               = 8;
   localparam int DIV_W               = 5;
   localparam int SHIFT_W             = 3;
   localparam int FREQ_W              = 32;
   localparam int TARGET_W            = 31;
   localparam int WORD_W              = 24;
   localparam int INDEX_W             = 7;
   localparam int CSR_ADDR_W          = 4;
   localparam int CSR_DATA_W          = 32;

   localparam logic [REF_W-1:0] REF_CLOCK_RESET = REF_W'(14318180);
   localparam logic [7:0]       ENTRIES_RESET   = 8'd1;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] CSR_IDX_FORMAT  = 2'd0;
   localparam logic [1:0] CSR_IDX_ENTRIES = 2'd1;
   localparam logic [1:0] CSR_IDX_REFCLK  = 2'd2;

   // request opcodes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // register word formats
   localparam logic [1:0] FMT_COMPACT = 2'd0;
   localparam logic [1:0] FMT_OFFSET  = 2'd1;
   localparam logic [1:0] FMT_PLAIN   = 2'd2;
   localparam logic [1:0] FMT_NONE    = 2'd3;

   typedef struct packed {
      logic                op;
      logic [INDEX_W-1:0]  entry_index;
      logic [MUL_W-1:0]    mult_value;
      logic [DIV_W-1:0]    div_value;
      logic [SHIFT_W-1:0]  post_shift;
      logic [TARGET_W-1:0] target_hz;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]  pll_word;
      logic [FREQ_W-1:0]  achieved_hz;
      logic [INDEX_W-1:0] best_index;
   } rsp_type;

   typedef struct packed {
      logic [MUL_W-1:0]   mul;
      logic [DIV_W-1:0]   div;
      logic [SHIFT_W-1:0] shift;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_DIV,
      ST_MUL,
      ST_DIFF,
      ST_BEST,
      ST_DONE
   } state_type;

   function automatic logic [WORD_W-1:0] pns_pack_word(input entry_type e,
                                                       input logic [1:0] fmt);
      logic [WORD_W-1:0] w;
      logic [MUL_W-1:0]  m2;
      logic [DIV_W-1:0]  d2;
      m2 = e.mul - MUL_W'(2);
      d2 = e.div - DIV_W'(2);
      unique case (fmt)
         FMT_COMPACT: w = (WORD_W'(e.mul) << 8) | (WORD_W'(e.shift) << 6) | WORD_W'(e.div);
         FMT_OFFSET:  w = (WORD_W'(d2) << 16) | (WORD_W'(e.shift) << 10) | WORD_W'(m2);
         FMT_PLAIN:   w = (WORD_W'(e.div) << 16) | (WORD_W'(e.shift) << 10) | WORD_W'(e.mul);
         default:     w = '0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* sv/pll_nearest_setting_search.sv */
// A table write leaves busy low, so writes can go back to back.
// A search scans N = entries_in_use entries (clamped to 1..TABLE_DEPTH); for each one
// it steps through the read, load, divide, multiply, difference and best-compare states.
// A new search is accepted only after busy falls; the restoring divider does the divide step.
// Reset: synchronous, active high; registers return to their reset values,
// the setting table is undefined until written.
// ----------------------------------------------------------------------------
// PLL nearest-setting search
// Table of PLL settings searched for the entry whose output frequency lies
// closest to a target, with an APB-style register port.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_nearest_setting_search #(
   parameter int TABLE_DEPTH = pns_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire pns_pkg::req_type                 req,
   output logic                                  rsp_valid,
   output pns_pkg::rsp_type                      rsp,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [pns_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [pns_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pns_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);
   import pns_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   state_type state_ff, state_in;

   logic [1:0]         word_format_ff;
   logic [7:0]         entries_in_use_ff;
   logic [REF_W-1:0]   ref_clock_ff;

   logic [IDX_W-1:0]    i_ff, last_ff, best_idx_ff;
   logic [TARGET_W-1:0] target_ff;
   entry_type           entry_ff, best_entry_ff;
   logic [FREQ_W-1:0]   prod_ff, freq_ff, diff_ff, best_freq_ff, best_diff_ff;

   logic               accept, csr_write;
   logic               mem_we, div_start, div_done;
   entry_type          rd_data, wr_data;
   logic [REF_W-1:0]   quotient;
   logic [IDX_W-1:0]   last_in;
   logic [8:0]         eiu_ext;
   logic [FREQ_W-1:0]  freq_calc, diff_calc, target_ext;
   logic               take;

   assign accept    = start && !busy;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   // ---------------- register port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         word_format_ff    <= FMT_COMPACT;
         entries_in_use_ff <= ENTRIES_RESET;
         ref_clock_ff      <= REF_CLOCK_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            CSR_IDX_FORMAT:  word_format_ff    <= pwdata[1:0];
            CSR_IDX_ENTRIES: entries_in_use_ff <= pwdata[7:0];
            CSR_IDX_REFCLK:  ref_clock_ff      <= pwdata[REF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         CSR_IDX_FORMAT:  prdata = CSR_DATA_W'(word_format_ff);
         CSR_IDX_ENTRIES: prdata = CSR_DATA_W'(entries_in_use_ff);
         CSR_IDX_REFCLK:  prdata = CSR_DATA_W'(ref_clock_ff);
         default:         prdata = '0;
      endcase
   end

   // ---------------- table and divider ----------------
   assign wr_data = '{mul: req.mult_value, div: req.div_value, shift: req.post_shift};

   pns_table_ram #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (IDX_W'(req.entry_index)),
      .wr_data (wr_data),
      .rd_addr (i_ff),
      .rd_data (rd_data)
   );

   pns_div_unit #(
      .DIVIDEND_W (REF_W),
      .DIVISOR_W  (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ref_clock_ff),
      .divisor  (rd_data.div),
      .done     (div_done),
      .quotient (quotient)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && req.op == OP_SEARCH) state_in = ST_READ;
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_MUL;
         ST_MUL:  state_in = ST_DIFF;
         ST_DIFF: state_in = ST_BEST;
         ST_BEST: state_in = (i_ff == last_ff) ? ST_DONE : ST_READ;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      div_start = (state_ff == ST_LOAD);
      mem_we    = (state_ff == ST_IDLE) && start && (req.op == OP_WRITE) &&
                  (32'(req.entry_index) < TABLE_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- datapath ----------------
   always_comb begin
      eiu_ext = {1'b0, entries_in_use_ff};
      if (entries_in_use_ff == 8'd0) begin
         last_in = '0;
      end else if (eiu_ext > 9'(TABLE_DEPTH)) begin
         last_in = IDX_W'(TABLE_DEPTH - 1);
      end else begin
         last_in = IDX_W'(eiu_ext - 9'd1);
      end
   end

   assign target_ext = FREQ_W'(target_ff);
   assign freq_calc  = prod_ff >> entry_ff.shift;
   assign diff_calc  = (freq_calc >= target_ext) ? freq_calc - target_ext
                                                 : target_ext - freq_calc;
   // first entry always seeds the best; later ones must be strictly closer
   assign take = (i_ff == '0) || (diff_ff < best_diff_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
      end else if (state_ff == ST_IDLE && accept) begin
         i_ff <= '0;
      end else if (state_ff == ST_BEST && i_ff != last_ff) begin
         i_ff <= i_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && accept) begin
         target_ff <= req.target_hz;
         last_ff   <= last_in;
      end
      if (state_ff == ST_LOAD) begin
         entry_ff <= rd_data;
      end
      if (state_ff == ST_MUL) begin
         // a zero divisor gives zero frequency
         prod_ff <= (entry_ff.div == '0) ? '0
                    : FREQ_W'(quotient) * FREQ_W'(entry_ff.mul);
      end
      if (state_ff == ST_DIFF) begin
         freq_ff <= freq_calc;
         diff_ff <= diff_calc;
      end
      if (state_ff == ST_BEST && take) begin
         best_idx_ff   <= i_ff;
         best_entry_ff <= entry_ff;
         best_freq_ff  <= freq_ff;
         best_diff_ff  <= diff_ff;
      end
   end

   assign rsp.pll_word    = pns_pack_word(best_entry_ff, word_format_ff);
   assign rsp.achieved_hz = best_freq_ff;
   assign rsp.best_index  = INDEX_W'(best_idx_ff);

   // ---------------- assertions ----------------
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");

   a_busy_needs_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start) && $past(req.op) == OP_SEARCH)
      else $error("busy rose without a search transaction");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> i_ff <= last_ff)
      else $error("scan index passed the last entry");

endmodule

`default_nettype wire

/* sv/pns_table_ram.sv */
// ----------------------------------------------------------------------------
// PLL setting table
// Single write port, single registered read port; contents undefined at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_table_ram #(
   parameter int DEPTH = pns_pkg::TABLE_DEPTH_DEFAULT,
   parameter int IDX_W = 7
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [IDX_W-1:0]   wr_addr,
   input  wire pns_pkg::entry_type wr_data,
   input  wire logic [IDX_W-1:0]   rd_addr,
   output pns_pkg::entry_type      rd_data
);
   import pns_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/pns_div_unit.sv */
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pns_div_unit #(
   parameter int DIVIDEND_W = pns_pkg::REF_W,
   parameter int DIVISOR_W  = pns_pkg::DIV_W
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);
   import pns_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      if (start) begin
         cnt_in = CNT_W'(DIVIDEND_W);
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = DIVISOR_W'(trial);
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* tb/tb_pll_nearest_setting_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PLL nearest-setting search testbench
// Loads setting tables, runs searches against a local scoreboard of the
// nearest-frequency pick, and reconfigures word format, entry count and
// reference clock over the APB port between bursts of traffic.
// ----------------------------------------------------------------------------

module tb_pll_nearest_setting_search;
   import pns_pkg::*;

   localparam int DEPTH         = TABLE_DEPTH_DEFAULT;
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 4;
   localparam int SEGMENTS      = 12;
   localparam int SEGMENT_ITEMS = 3;
   localparam int REQ_W         = $bits(req_type);

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      item;
      bit           literal;
      rsp_type      want;
      logic [1:0]   csr_idx;
      logic [31:0]  csr_val;
   } script_row_type;

   logic                  clock   = 1'b0;
   logic                  reset   = 1'b1;
   logic                  start   = 1'b0;
   logic                  busy;
   req_type               req     = '0;
   logic                  rsp_valid;
   rsp_type               rsp;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // sideband that travels with req: a hand-written expectation for this transaction
   logic    req_has_literal = 1'b0;
   rsp_type req_literal     = '0;

   // scoreboard copy of the registers and the setting table
   logic [1:0]       cfg_format  = FMT_COMPACT;
   logic [7:0]       cfg_entries = ENTRIES_RESET;
   logic [REF_W-1:0] cfg_ref     = REF_CLOCK_RESET;
   entry_type        setting_tbl [DEPTH];

   // table contents as planned by the stimulus side
   entry_type planned_tbl [DEPTH];
   bit        planned_written [DEPTH];
   int        filled = 0;

   rsp_type   pending_picks [$];
   int        errors          = 0;
   int        quiet_cycles    = 0;
   int        sender_idle_pct = 0;

   pll_nearest_setting_search u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #10 clock = ~clock;

   function automatic int entries_searched();
      if (cfg_entries == 8'd0) return 1;
      if (int'(cfg_entries) > DEPTH) return DEPTH;
      return int'(cfg_entries);
   endfunction

   function automatic logic [31:0] setting_freq(entry_type e);
      logic [31:0] quot;
      if (e.div == '0) return '0;
      quot = 32'(cfg_ref) / 32'(e.div);
      quot = quot * 32'(e.mul);
      return quot >> e.shift;
   endfunction

   function automatic logic [WORD_W-1:0] setting_word(entry_type e);
      logic [7:0] mul_less;
      logic [4:0] div_less;
      mul_less = e.mul - 8'd2;
      div_less = e.div - 5'd2;
      case (cfg_format)
         FMT_COMPACT: return {8'b0, e.mul, 8'b0} | {15'b0, e.shift, 6'b0} | {19'b0, e.div};
         FMT_OFFSET:  return {3'b0, div_less, 3'b0, e.shift, 2'b0, mul_less};
         FMT_PLAIN:   return {3'b0, e.div, 3'b0, e.shift, 2'b0, e.mul};
         default:     return '0;
      endcase
   endfunction

   function automatic rsp_type nearest_setting(logic [TARGET_W-1:0] target);
      logic [31:0] freq, gap, best_gap, goal;
      rsp_type     pick;
      goal     = 32'(target);
      pick     = '0;
      best_gap = '0;
      for (int i = 0; i < entries_searched(); i++) begin
         freq = setting_freq(setting_tbl[i]);
         gap  = (freq >= goal) ? freq - goal : goal - freq;
         // strict compare keeps the lowest slot on a tie
         if (i == 0 || gap < best_gap) begin
            best_gap         = gap;
            pick.achieved_hz = freq;
            pick.best_index  = 7'(i);
         end
      end
      pick.pll_word = setting_word(setting_tbl[pick.best_index]);
      return pick;
   endfunction

   function automatic logic [31:0] csr_shadow(logic [1:0] idx);
      case (idx)
         CSR_IDX_FORMAT:  return 32'(cfg_format);
         CSR_IDX_ENTRIES: return 32'(cfg_entries);
         CSR_IDX_REFCLK:  return 32'(cfg_ref);
         default:         return '0;
      endcase
   endfunction

   function automatic script_row_type blank_row(row_kind_type kind);
      script_row_type row;
      row.kind    = kind;
      row.item    = REQ_W'({$urandom(), $urandom()});
      row.literal = 1'b0;
      row.want    = '0;
      row.csr_idx = '0;
      row.csr_val = '0;
      return row;
   endfunction

   function automatic script_row_type load_row(int slot, int m, int d, int s);
      script_row_type row;
      row                  = blank_row(ROW_ITEM);
      row.item.op          = OP_WRITE;
      row.item.entry_index = 7'(slot);
      row.item.mult_value  = 8'(m);
      row.item.div_value   = 5'(d);
      row.item.post_shift  = 3'(s);
      return row;
   endfunction

   function automatic script_row_type find_row(logic [TARGET_W-1:0] target);
      script_row_type row;
      row                = blank_row(ROW_ITEM);
      row.item.op        = OP_SEARCH;
      row.item.target_hz = target;
      return row;
   endfunction

   function automatic script_row_type known_row(logic [TARGET_W-1:0] target,
                                                logic [23:0] word,
                                                logic [31:0] hz, int slot);
      script_row_type row;
      row         = find_row(target);
      row.literal = 1'b1;
      row.want    = {word, hz, 7'(slot)};
      return row;
   endfunction

   function automatic script_row_type csr_row(logic [1:0] idx, logic [31:0] value);
      script_row_type row;
      row         = blank_row(ROW_CSR);
      row.csr_idx = idx;
      row.csr_val = value;
      return row;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endtask

   // Returns with psel and penable low and the bus idle, so the next transfer starts clean.
   task automatic csr_read(input logic [1:0] idx, output logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         CSR_IDX_FORMAT:  cfg_format  = value[1:0];
         CSR_IDX_ENTRIES: cfg_entries = value[7:0];
         CSR_IDX_REFCLK:  cfg_ref     = value[REF_W-1:0];
         default: ;
      endcase
      csr_read(idx, readback);
      check_field("register readback", csr_shadow(idx), readback);
   endtask

   // Leaves start high on return so a following transaction goes out back to back.
   task automatic send_item(input req_type item, input bit literal, input rsp_type want);
      int slot;
      slot = int'(item.entry_index);
      if (item.op == OP_WRITE) begin
         planned_tbl[slot]     = {item.mult_value, item.div_value, item.post_shift};
         planned_written[slot] = 1'b1;
         while (filled < DEPTH && planned_written[filled]) filled++;
      end
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req             <= item;
      req_has_literal <= literal;
      req_literal     <= want;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Hold off until every pending search has reported and the block is quiet.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_picks.size() == 0) begin
               $error("unexpected result: word 0x%0h hz 0x%0h index %0d",
                      rsp.pll_word, rsp.achieved_hz, rsp.best_index);
               errors++;
            end else begin
               want = pending_picks.pop_front();
               check_field("pll_word", 32'(want.pll_word), 32'(rsp.pll_word));
               check_field("achieved_hz", want.achieved_hz, rsp.achieved_hz);
               check_field("best_index", 32'(want.best_index), 32'(rsp.best_index));
            end
         end
         if (start && !busy) begin
            if (req.op == OP_WRITE)
               setting_tbl[req.entry_index] = {req.mult_value, req.div_value, req.post_shift};
            else
               pending_picks.push_back(req_has_literal ? req_literal
                                                       : nearest_setting(req.target_hz));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      script_row_type       script [$];
      req_type              item;
      entry_type            copy;
      logic [31:0]          value;
      logic [31:0]          freq;
      int                   pick;
      int                   roll;
      int                   slot;
      for (int i = 0; i < DEPTH; i++) begin
         setting_tbl[i]     = '0;
         planned_tbl[i]     = '0;
         planned_written[i] = 1'b0;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_read(CSR_IDX_FORMAT, value);
      check_field("word_format after reset", csr_shadow(CSR_IDX_FORMAT), value);
      csr_read(CSR_IDX_ENTRIES, value);
      check_field("entries_in_use after reset", csr_shadow(CSR_IDX_ENTRIES), value);
      csr_read(CSR_IDX_REFCLK, value);
      check_field("ref_clock_hz after reset", csr_shadow(CSR_IDX_REFCLK), value);

      // directed: reset defaults, extremes, ties, zero divisor, every format
      script.push_back(load_row(0, 2, 2, 0));
      script.push_back(known_row('0, 24'h000202, 32'd14318180, 0));
      script.push_back(known_row('1, 24'h000202, 32'd14318180, 0));
      script.push_back(load_row(1, 255, 31, 7));
      script.push_back(load_row(2, 0, 0, 0));
      script.push_back(load_row(3, 1, 1, 0));
      script.push_back(load_row(127, 255, 2, 0));
      script.push_back(csr_row(CSR_IDX_ENTRIES, 32'd4));
      script.push_back(known_row(31'd14318180, 24'h000202, 32'd14318180, 0));
      script.push_back(known_row('0, 24'h0, 32'd0, 2));
      script.push_back(find_row('1));
      script.push_back(csr_row(CSR_IDX_FORMAT, 32'(FMT_OFFSET)));
      script.push_back(find_row('0));
      script.push_back(find_row(31'd14318180));
      script.push_back(csr_row(CSR_IDX_FORMAT, 32'(FMT_PLAIN)));
      script.push_back(find_row('1));
      script.push_back(find_row('0));
      script.push_back(csr_row(CSR_IDX_FORMAT, 32'(FMT_NONE)));
      script.push_back(known_row('0, 24'h0, 32'd0, 2));
      script.push_back(csr_row(CSR_IDX_REFCLK, 32'hFFFF_FFFF));
      script.push_back(csr_row(CSR_IDX_FORMAT, 32'(FMT_COMPACT)));
      script.push_back(load_row(4, 255, 2, 0));
      script.push_back(csr_row(CSR_IDX_ENTRIES, 32'd5));
      script.push_back(find_row('1));
      script.push_back(find_row('0));
      script.push_back(csr_row(CSR_IDX_ENTRIES, 32'd0));
      script.push_back(find_row(31'd5));
      script.push_back(csr_row(CSR_IDX_REFCLK, 32'd1));
      script.push_back(csr_row(CSR_IDX_ENTRIES, 32'd5));
      script.push_back(find_row(31'd1));

      foreach (script[k]) begin
         if (script[k].kind == ROW_CSR) begin
            settle();
            csr_write(script[k].csr_idx, script[k].csr_val);
         end else begin
            send_item(script[k].item, script[k].literal, script[k].want);
         end
      end

      // random: bursts under a fresh configuration, sender idling light, heavy, then not at all
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         sender_idle_pct = (seg < SEGMENTS / 3) ? 15 : (seg < 2 * SEGMENTS / 3) ? 83 : 0;
         settle();
         csr_write(CSR_IDX_FORMAT, $urandom());
         case ($urandom_range(0, 3))
            0:       value = 32'd1;
            1:       value = 32'hFFFF_FFFF;
            2:       value = 32'(REF_CLOCK_RESET);
            default: value = $urandom();
         endcase
         csr_write(CSR_IDX_REFCLK, value);
         // never search past the written prefix of the table
         pick = $urandom_range(0, (filled < 16) ? filled : 16);
         if ($urandom_range(0, 5) == 0) pick = filled;
         csr_write(CSR_IDX_ENTRIES, ($urandom() & 32'hFFFF_FF00) | 32'(pick));

         for (int k = 0; k < SEGMENT_ITEMS; k++) begin
            if ($urandom_range(0, 14) == 0) settle();
            item = REQ_W'({$urandom(), $urandom()});
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 40) begin
               item.op = OP_WRITE;
               if (roll < 45 && filled < DEPTH) slot = filled;
               else if (roll < 75) slot = $urandom_range(0, filled - 1);
               else slot = $urandom_range(0, DEPTH - 1);
               item.entry_index = 7'(slot);
               // duplicate an existing setting now and then to force ties
               if ($urandom_range(0, 6) == 0) begin
                  copy = planned_tbl[$urandom_range(0, filled - 1)];
                  {item.mult_value, item.div_value, item.post_shift} = copy;
               end
            end else begin
               item.op = OP_SEARCH;
               if (roll < 50) begin
                  freq = setting_freq(planned_tbl[$urandom_range(0, entries_searched() - 1)]);
                  if ($urandom_range(0, 1) == 1) freq = freq + $urandom_range(0, 3);
                  else freq = freq - $urandom_range(0, 3);
                  item.target_hz = freq[TARGET_W-1:0];
               end else if (roll < 60) begin
                  item.target_hz = '0;
               end else if (roll < 70) begin
                  item.target_hz = '1;
               end
            end
            send_item(item, 1'b0, '0);
         end
      end

      // full depth: fill the rest of the table, then search all of it
      for (int s = 0; s < DEPTH; s++) begin
         if (!planned_written[s]) begin
            item             = REQ_W'({$urandom(), $urandom()});
            item.op          = OP_WRITE;
            item.entry_index = 7'(s);
            send_item(item, 1'b0, '0);
         end
      end
      settle();
      csr_write(CSR_IDX_ENTRIES, 32'(DEPTH));
      freq    = setting_freq(planned_tbl[$urandom_range(0, DEPTH - 1)]);
      item    = REQ_W'({$urandom(), $urandom()});
      item.op = OP_SEARCH;
      send_item(item, 1'b0, '0);
      item.target_hz = freq[TARGET_W-1:0];
      send_item(item, 1'b0, '0);
      settle();
      csr_write(CSR_IDX_ENTRIES, 32'hFFFF_FFFF);
      csr_write(CSR_IDX_FORMAT, $urandom());
      csr_write(CSR_IDX_REFCLK, $urandom());
      item.target_hz = '1;
      send_item(item, 1'b0, '0);
      item.target_hz = '0;
      send_item(item, 1'b0, '0);

      settle();
      repeat (40) @(posedge clock);
      if (errors == 0 && pending_picks.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
